[hw/rtl/rv32i_op_imm_execute_defines.svh]
// Assertion helpers shared by the RTL. Checks vanish when SYNTHESIS is defined.
`ifndef RV32I_OP_IMM_EXECUTE_DEFINES_SVH
`define RV32I_OP_IMM_EXECUTE_DEFINES_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge out of reset.
`define RVOPI_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("rvopi check failed");
// Consequent must hold in the same cycle as the antecedent.
`define RVOPI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rvopi check failed");
`else
`define RVOPI_ASSERT(label, clk, rst_n, prop)
`define RVOPI_ASSERT_IMP(label, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/rvopi_pkg.sv]
package rvopi_pkg;

    localparam int XLEN        = 32;
    localparam int REG_IDX_W   = 5;
    localparam int IMM_W       = 12;
    localparam int SHAMT_W     = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        F3_ADDI  = 3'd0,
        F3_SLLI  = 3'd1,
        F3_SLTI  = 3'd2,
        F3_SLTIU = 3'd3,
        F3_XORI  = 3'd4,
        F3_SRXI  = 3'd5,
        F3_ORI   = 3'd6,
        F3_ANDI  = 3'd7
    } t_funct3;

    // Decoded operation handed from the front end to the execute side
    typedef struct packed {
        logic [REG_IDX_W-1:0] rd;
        logic [REG_IDX_W-1:0] rs1;
        logic                 src_ok;
        logic                 wr_en;
        t_funct3              funct3;
        logic                 arith;
        logic [XLEN-1:0]      imm;
    } t_op;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

[hw/rtl/rvopi_front.sv]
module rvopi_front #(
    parameter int REGISTER_COUNT = 32
) (
    input  logic                        i_valid,
    input  logic [31:0]                 i_instruction,
    output logic                        o_stall,
    input  rvopi_pkg::t_q_stat          i_q_stat,
    output logic                        o_push,
    output rvopi_pkg::t_op              o_op
);

    logic [rvopi_pkg::REG_IDX_W-1:0] rd;
    logic [rvopi_pkg::REG_IDX_W-1:0] rs1;

    assign rd  = i_instruction[11:7];
    assign rs1 = i_instruction[19:15];

    assign o_stall = i_q_stat.full;
    assign o_push  = i_valid && !i_q_stat.full;

    always_comb begin
        o_op.rd     = rd;
        o_op.rs1    = rs1;
        // x0 and out-of-range sources read as zero
        o_op.src_ok = (rs1 != '0) && (int'(rs1) < REGISTER_COUNT);
        o_op.wr_en  = (rd != '0) && (int'(rd) < REGISTER_COUNT);
        o_op.funct3 = rvopi_pkg::t_funct3'(i_instruction[14:12]);
        o_op.arith  = i_instruction[30];
        o_op.imm    = {{(rvopi_pkg::XLEN - rvopi_pkg::IMM_W){i_instruction[31]}},
                       i_instruction[31:20]};
    end

endmodule

[hw/rtl/rvopi_queue.sv]
`include "rv32i_op_imm_execute_defines.svh"

module rvopi_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  rvopi_pkg::t_op     i_op,
    input  logic               i_pop,
    output rvopi_pkg::t_op     o_op,
    output rvopi_pkg::t_q_stat o_stat
);

    rvopi_pkg::t_op                   r_mem [rvopi_pkg::QUEUE_DEPTH];
    logic [rvopi_pkg::QPTR_W-1:0]     r_wptr, n_wptr;
    logic [rvopi_pkg::QPTR_W-1:0]     r_rptr, n_rptr;
    logic [rvopi_pkg::QCNT_W-1:0]     r_count, n_count;

    function automatic logic [rvopi_pkg::QPTR_W-1:0] ptr_inc(
        input logic [rvopi_pkg::QPTR_W-1:0] p
    );
        if (p == rvopi_pkg::QPTR_W'(rvopi_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + rvopi_pkg::QPTR_W'(1);
    endfunction

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == rvopi_pkg::QCNT_W'(rvopi_pkg::QUEUE_DEPTH));
    assign o_op         = r_mem[r_rptr];

    always_comb begin
        n_wptr  = i_push ? ptr_inc(r_wptr) : r_wptr;
        n_rptr  = i_pop  ? ptr_inc(r_rptr) : r_rptr;
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + rvopi_pkg::QCNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - rvopi_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_op;
        end
    end

    `RVOPI_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= rvopi_pkg::QCNT_W'(rvopi_pkg::QUEUE_DEPTH))
    `RVOPI_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, o_stat.full, !i_push)
    `RVOPI_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, o_stat.empty, !i_pop)

endmodule

[hw/rtl/rvopi_back.sv]
`include "rv32i_op_imm_execute_defines.svh"

module rvopi_back #(
    parameter int REGISTER_COUNT = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  rvopi_pkg::t_op           i_op,
    input  rvopi_pkg::t_q_stat       i_q_stat,
    output logic                     o_pop,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [4:0]               o_dest_index,
    output logic [31:0]              o_write_value,
    output logic                     o_write_done
);

    localparam int IDX_W = $clog2(REGISTER_COUNT);

    logic [rvopi_pkg::XLEN-1:0]    r_rf [REGISTER_COUNT];
    logic                          r_valid, n_valid;
    logic [4:0]                    r_dest;
    logic [rvopi_pkg::XLEN-1:0]    r_value;
    logic                          r_done;

    logic [rvopi_pkg::XLEN-1:0]    src;
    logic [rvopi_pkg::XLEN-1:0]    result;
    logic [rvopi_pkg::SHAMT_W-1:0] shamt;

    // Advance when the output register is free or being drained
    assign o_pop = !i_q_stat.empty && (!r_valid || !i_stall);

    assign src   = i_op.src_ok ? r_rf[i_op.rs1[IDX_W-1:0]] : '0;
    assign shamt = i_op.imm[rvopi_pkg::SHAMT_W-1:0];

    always_comb begin
        case (i_op.funct3)
            rvopi_pkg::F3_ADDI:  result = src + i_op.imm;
            rvopi_pkg::F3_SLLI:  result = src << shamt;
            rvopi_pkg::F3_SLTI:  result = rvopi_pkg::XLEN'($signed(src) < $signed(i_op.imm));
            rvopi_pkg::F3_SLTIU: result = rvopi_pkg::XLEN'(src < i_op.imm);
            rvopi_pkg::F3_XORI:  result = src ^ i_op.imm;
            rvopi_pkg::F3_SRXI: begin
                if (i_op.arith) begin
                    result = $unsigned($signed(src) >>> shamt);
                end else begin
                    result = src >> shamt;
                end
            end
            rvopi_pkg::F3_ORI:   result = src | i_op.imm;
            rvopi_pkg::F3_ANDI:  result = src & i_op.imm;
            default:             result = '0;
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            for (int i = 0; i < REGISTER_COUNT; i++) begin
                r_rf[i] <= '0;
            end
        end else begin
            r_valid <= n_valid;
            if (o_pop && i_op.wr_en) begin
                r_rf[i_op.rd[IDX_W-1:0]] <= result;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_dest  <= i_op.rd;
            r_value <= i_op.wr_en ? result : '0;
            r_done  <= i_op.wr_en;
        end
    end

    assign o_valid       = r_valid;
    assign o_dest_index  = r_dest;
    assign o_write_value = r_value;
    assign o_write_done  = r_done;

    `RVOPI_ASSERT(a_x0_zero, i_clk, i_rst_n, r_rf[0] == '0)
    `RVOPI_ASSERT_IMP(a_skip_zero, i_clk, i_rst_n, r_valid && !r_done, r_value == '0)
    `RVOPI_ASSERT_IMP(a_out_hold, i_clk, i_rst_n, r_valid && i_stall, !o_pop)

endmodule

[hw/rtl/rv32i_op_imm_execute.sv]
// RV32I register-immediate execute block: each accepted instruction word is decoded
// (rd, rs1, funct3, sign-extended immediate) into a two-entry queue, then executed
// against a REGISTER_COUNT-entry register file and reported as one result. Sustained
// rate is one instruction per cycle while i_stall is low. An instruction passes the
// queue slot, then the output register, before its result is valid; register read
// and ALU are combinational, and write-back is made with the load of the output
// register in the execute side. Shifts use immediate bits 4..0, bit 30
// picks srai over srli, x0 and indexes at or above REGISTER_COUNT read as zero and are
// never written (write_done low, write_value zero). Reset clears the register file at
// once; there is no clearing pass. The opcode field is not checked.
module rv32i_op_imm_execute #(
    parameter int REGISTER_COUNT = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [31:0] i_instruction,
    output logic        o_stall,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [4:0]  o_dest_index,
    output logic [31:0] o_write_value,
    output logic        o_write_done
);

    rvopi_pkg::t_op     front_op;
    rvopi_pkg::t_op     queue_op;
    rvopi_pkg::t_q_stat q_stat;
    logic               push;
    logic               pop;

    rvopi_front #(
        .REGISTER_COUNT(REGISTER_COUNT)
    ) u_front (
        .i_valid       (i_valid),
        .i_instruction (i_instruction),
        .o_stall       (o_stall),
        .i_q_stat      (q_stat),
        .o_push        (push),
        .o_op          (front_op)
    );

    rvopi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .i_pop   (pop),
        .o_op    (queue_op),
        .o_stat  (q_stat)
    );

    rvopi_back #(
        .REGISTER_COUNT(REGISTER_COUNT)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (queue_op),
        .i_q_stat      (q_stat),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_dest_index  (o_dest_index),
        .o_write_value (o_write_value),
        .o_write_done  (o_write_done)
    );

endmodule
